// ===== rtl/dsbu_pkg.sv =====
`timescale 1ns / 1ps
// Package for the debugger step and breakpoint unit.
// Holds the table geometry, codes, word types and status structs; no dependencies.
package dsbu_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CFG_W       = 9;
  localparam int LIM_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int LINE_W      = 24;
  localparam int HIT_W       = 8;
  localparam int DEPTH_W     = 16;

  localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 16'sh7FFF;
  localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = -16'sh8000;

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_MODE  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    EV_CALL   = 2'd0,
    EV_RETURN = 2'd1,
    EV_LINE   = 2'd2,
    EV_OTHER  = 2'd3
  } ev_e;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_INTO = 2'd1,
    MODE_OVER = 2'd2,
    MODE_OUT  = 2'd3
  } mode_e;

  localparam logic [1:0] NOTIFY_NONE = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } scan_state_e;

  typedef struct packed {
    kind_e             kind;
    ev_e               event_type;
    logic [LINE_W-1:0] line_number;
    logic              source_present;
    logic [7:0]        entry_index;
    logic [LINE_W-1:0] entry_line;
    logic              entry_source_present;
    mode_e             new_mode;
  } in_word_t;

  typedef struct packed {
    logic             break_now;
    logic [1:0]       notify;
    logic             hit_found;
    logic [HIT_W-1:0] hit_index;
    mode_e            mode_now;
  } out_word_t;

  typedef struct packed {
    logic              src;
    logic [LINE_W-1:0] line;
  } bp_entry_t;

  localparam int ENTRY_W = $bits(bp_entry_t);

  // Decision of the step logic for the word being accepted.
  typedef struct packed {
    logic brk;
    logic scan;
  } step_res_t;

  typedef struct packed {
    logic              start;
    logic              need_scan;
    logic [LINE_W-1:0] line;
  } scan_start_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic hit;
  } scan_stat_t;

endpackage

// ===== rtl/dsbu_ram.sv =====
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with a registered read.
// Stand-alone; no package dependency.
module dsbu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                            clk_i,
  input  logic                                            we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    waddr_i,
  input  logic [WIDTH-1:0]                                wdata_i,
  input  logic                                            re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    raddr_i,
  output logic [WIDTH-1:0]                                rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dsbu_step.sv =====
`timescale 1ns / 1ps
// Step mode and nesting depth registers with the step decision for each word.
// Depends on dsbu_pkg.
module dsbu_step (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  dsbu_pkg::in_word_t   word_i,
  output dsbu_pkg::step_res_t  res_o,
  output dsbu_pkg::mode_e      mode_o
);

  dsbu_pkg::mode_e                           mode_q, mode_d;
  logic signed [dsbu_pkg::DEPTH_W-1:0]       depth_q, depth_d;
  logic signed [dsbu_pkg::DEPTH_W-1:0]       depth_inc, depth_dec;

  always_comb begin
    depth_inc = (depth_q != dsbu_pkg::DEPTH_MAX) ? depth_q + 16'sd1 : depth_q;
    depth_dec = (depth_q != dsbu_pkg::DEPTH_MIN) ? depth_q - 16'sd1 : depth_q;
  end

  always_comb begin
    mode_d    = mode_q;
    depth_d   = depth_q;
    res_o.brk  = 1'b0;
    res_o.scan = 1'b1;
    if (word_i.kind == dsbu_pkg::KIND_MODE) begin
      mode_d = word_i.new_mode;
    end else if (word_i.kind == dsbu_pkg::KIND_EVENT) begin
      unique case (mode_q)
        dsbu_pkg::MODE_INTO: begin
          if (word_i.event_type == dsbu_pkg::EV_LINE) begin
            depth_d    = '0;
            res_o.brk  = 1'b1;
            res_o.scan = 1'b0;
          end
        end
        dsbu_pkg::MODE_OUT: begin
          // Leaving the frame we stepped out of turns into stepping over.
          if (word_i.event_type == dsbu_pkg::EV_RETURN) begin
            if (depth_q == '0) begin
              mode_d = dsbu_pkg::MODE_OVER;
            end else begin
              depth_d = depth_dec;
            end
          end
        end
        dsbu_pkg::MODE_OVER: begin
          priority if (word_i.event_type == dsbu_pkg::EV_LINE && depth_q == '0) begin
            res_o.brk  = 1'b1;
            res_o.scan = 1'b0;
          end else if (word_i.event_type == dsbu_pkg::EV_CALL) begin
            depth_d = depth_inc;
          end else if (word_i.event_type == dsbu_pkg::EV_RETURN) begin
            depth_d = depth_dec;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= dsbu_pkg::MODE_NONE;
      depth_q <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      depth_q <= depth_d;
    end
  end

  assign mode_o = mode_q;

endmodule

// ===== rtl/dsbu_scan.sv =====
`timescale 1ns / 1ps
// Breakpoint table scan sequencer: sequences each word and walks the table RAM.
// Depends on dsbu_pkg and reads through the dsbu_ram read port.
module dsbu_scan (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dsbu_pkg::scan_start_t                start_i,
  input  logic [dsbu_pkg::LIM_W-1:0]           lim_i,
  input  logic                                 load_i,
  output logic                                 re_o,
  output logic [dsbu_pkg::ADDR_W-1:0]          raddr_o,
  input  dsbu_pkg::bp_entry_t                  rdata_i,
  output dsbu_pkg::scan_stat_t                 stat_o,
  output logic [dsbu_pkg::HIT_W-1:0]           last_hit_o
);

  localparam int XW = (dsbu_pkg::ADDR_W > dsbu_pkg::HIT_W) ? dsbu_pkg::ADDR_W
                                                            : dsbu_pkg::HIT_W;

  dsbu_pkg::scan_state_e               state_q, state_d;
  logic [dsbu_pkg::CNT_W-1:0]          rd_idx_q, rd_idx_d;
  logic                                cmp_vld_q, cmp_vld_d;
  logic [dsbu_pkg::ADDR_W-1:0]         cmp_idx_q, cmp_idx_d;
  logic                                hit_q, hit_d;
  logic [dsbu_pkg::HIT_W-1:0]          last_hit_q, last_hit_d;
  logic [dsbu_pkg::LINE_W-1:0]         line_q, line_d;
  logic [XW-1:0]                       cmp_idx_x;
  logic                                cmp_last;

  assign cmp_idx_x = XW'(cmp_idx_q);
  assign cmp_last  = (dsbu_pkg::LIM_W'(cmp_idx_q) + dsbu_pkg::LIM_W'(1)) == lim_i;
  assign raddr_o   = rd_idx_q[dsbu_pkg::ADDR_W-1:0];

  always_comb begin
    state_d    = state_q;
    rd_idx_d   = rd_idx_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    hit_d      = hit_q;
    last_hit_d = last_hit_q;
    line_d     = line_q;
    re_o       = 1'b0;
    unique case (state_q)
      dsbu_pkg::S_IDLE: begin
        if (start_i.start) begin
          rd_idx_d = '0;
          hit_d    = 1'b0;
          line_d   = start_i.line;
          state_d  = start_i.need_scan ? dsbu_pkg::S_SCAN : dsbu_pkg::S_DONE;
        end
      end
      dsbu_pkg::S_SCAN: begin
        // One read is issued per cycle; the entry read in the previous cycle
        // is checked alongside it, so a stop may leave one spare read behind.
        re_o = dsbu_pkg::LIM_W'(rd_idx_q) < lim_i;
        if (re_o) begin
          rd_idx_d  = rd_idx_q + dsbu_pkg::CNT_W'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = raddr_o;
        end
        if (cmp_vld_q) begin
          priority if (!rdata_i.src) begin
            cmp_vld_d = 1'b0;
            state_d   = dsbu_pkg::S_DONE;
          end else if (rdata_i.line == line_q) begin
            hit_d      = 1'b1;
            last_hit_d = cmp_idx_x[dsbu_pkg::HIT_W-1:0];
            cmp_vld_d  = 1'b0;
            state_d    = dsbu_pkg::S_DONE;
          end else if (cmp_last) begin
            cmp_vld_d = 1'b0;
            state_d   = dsbu_pkg::S_DONE;
          end
        end
      end
      dsbu_pkg::S_DONE: begin
        if (load_i) begin
          state_d = dsbu_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dsbu_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dsbu_pkg::S_IDLE;
      cmp_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      last_hit_q <= '0;
    end else begin
      state_q    <= state_d;
      cmp_vld_q  <= cmp_vld_d;
      hit_q      <= hit_d;
      last_hit_q <= last_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_idx_d;
    cmp_idx_q <= cmp_idx_d;
    line_q    <= line_d;
  end

  assign stat_o.idle = state_q == dsbu_pkg::S_IDLE;
  assign stat_o.done = state_q == dsbu_pkg::S_DONE;
  assign stat_o.hit  = hit_q;
  assign last_hit_o  = last_hit_q;

endmodule

// ===== rtl/debug_step_breakpoint_unit.sv =====
`timescale 1ns / 1ps
// Debugger step and breakpoint unit, top level. One word is worked on at a time.
// Table writes, mode changes and events that need no scan go from acceptance to the
// done state and then into the output register; an event that needs a scan first reads
// the table, one entry per cycle through the table RAM read port. A new word is taken
// only once the last result is loaded; a result may wait in the output register meanwhile.
// Reset clears mode, depth, last hit, active count and handshakes; the table holds
// no reset.
module debug_step_breakpoint_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dsbu_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  dsbu_pkg::in_word_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output dsbu_pkg::out_word_t            out_data_o
);

  localparam int IDXC_W = (dsbu_pkg::ADDR_W + 1 > 8) ? dsbu_pkg::ADDR_W + 1 : 8;

  logic [dsbu_pkg::CFG_W-1:0]   active_count_q;
  logic [dsbu_pkg::LIM_W-1:0]   lim;
  logic                         accept;
  logic                         is_event;
  logic                         load;
  dsbu_pkg::step_res_t          step_res;
  dsbu_pkg::mode_e              mode;
  dsbu_pkg::scan_start_t        start;
  dsbu_pkg::scan_stat_t         stat;
  logic [dsbu_pkg::HIT_W-1:0]   last_hit;
  logic                         re;
  logic [dsbu_pkg::ADDR_W-1:0]  raddr;
  logic [dsbu_pkg::ENTRY_W-1:0] rdata_raw;
  dsbu_pkg::bp_entry_t          rdata;
  dsbu_pkg::bp_entry_t          wentry;
  logic                         we;

  logic                         brk_q, brk_d;
  logic                         is_line_q, is_line_d;
  logic [1:0]                   notify_q, notify_d;
  logic                         out_valid_q, out_valid_d;
  dsbu_pkg::out_word_t          out_data_q, out_data_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_count_q <= '0;
    end else if (cfg_we_i) begin
      active_count_q <= cfg_wdata_i;
    end
  end

  // Counts beyond the table depth scan the whole table.
  assign lim = (dsbu_pkg::LIM_W'(active_count_q) > dsbu_pkg::LIM_W'(dsbu_pkg::TABLE_DEPTH))
             ? dsbu_pkg::LIM_W'(dsbu_pkg::TABLE_DEPTH)
             : dsbu_pkg::LIM_W'(active_count_q);

  assign in_stall_o = !stat.idle;
  assign accept     = in_valid_i && stat.idle;
  assign is_event   = in_data_i.kind == dsbu_pkg::KIND_EVENT;

  dsbu_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .word_i   (in_data_i),
    .res_o    (step_res),
    .mode_o   (mode)
  );

  assign start.start     = accept;
  assign start.need_scan = is_event && step_res.scan && in_data_i.source_present
                           && (lim != '0);
  assign start.line      = in_data_i.line_number;

  // Table writes go straight into the RAM; no scan is running at that point.
  assign we = accept && (in_data_i.kind == dsbu_pkg::KIND_WRITE)
              && (IDXC_W'(in_data_i.entry_index) < IDXC_W'(dsbu_pkg::TABLE_DEPTH));
  assign wentry.src  = in_data_i.entry_source_present;
  assign wentry.line = in_data_i.entry_line;

  dsbu_ram #(
    .WIDTH (dsbu_pkg::ENTRY_W),
    .DEPTH (dsbu_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (dsbu_pkg::ADDR_W'(in_data_i.entry_index)),
    .wdata_i (wentry),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata = dsbu_pkg::bp_entry_t'(rdata_raw);

  dsbu_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .lim_i      (lim),
    .load_i     (load),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata),
    .stat_o     (stat),
    .last_hit_o (last_hit)
  );

  always_comb begin
    brk_d     = brk_q;
    is_line_d = is_line_q;
    notify_d  = notify_q;
    if (accept) begin
      brk_d     = is_event && step_res.brk;
      is_line_d = is_event && (in_data_i.event_type == dsbu_pkg::EV_LINE);
      notify_d  = is_event ? in_data_i.event_type : dsbu_pkg::NOTIFY_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    brk_q     <= brk_d;
    is_line_q <= is_line_d;
    notify_q  <= notify_d;
  end

  assign load = stat.done && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (load) begin
      out_valid_d          = 1'b1;
      out_data_d.break_now = brk_q || (stat.hit && is_line_q);
      out_data_d.notify    = notify_q;
      out_data_d.hit_found = stat.hit;
      out_data_d.hit_index = last_hit;
      out_data_d.mode_now  = mode;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for debug_step_breakpoint_unit: directed rows, then random words.
// Depends on rtl/dsbu_pkg.sv and rtl/debug_step_breakpoint_unit.sv; results are checked
// against an in-bench model of the step logic and the breakpoint scan.
module tb_top;
  import dsbu_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int N_PHASES    = 9;
  localparam int N_DIRECTED  = 24;
  localparam int NO_CFG      = -1;

  typedef struct {
    int        cfg;
    in_word_t  w;
    out_word_t want;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  in_word_t             in_data;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_data;

  // Model state of the unit.
  mode_e                    pm_mode;
  logic signed [DEPTH_W-1:0] pm_depth;
  logic [HIT_W-1:0]         pm_last;
  logic [CFG_W-1:0]         pm_count;
  logic [LINE_W-1:0]        pm_line    [TABLE_DEPTH];
  logic                     pm_src     [TABLE_DEPTH];
  logic                     pm_written [TABLE_DEPTH];

  out_word_t   verdict_q [$];
  int unsigned bad_words;
  int unsigned quiet_cycles;
  logic        burst;
  logic        hold_req;

  debug_step_breakpoint_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int scanned_entries();
    return (pm_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(pm_count);
  endfunction

  // Works out the unit's answer to one word and updates the model state.
  function automatic out_word_t decide_word(in_word_t w);
    out_word_t r;
    logic      do_scan;
    int        i;
    r.break_now = 1'b0;
    r.notify    = NOTIFY_NONE;
    r.hit_found = 1'b0;
    case (w.kind)
      KIND_WRITE: begin
        pm_line[w.entry_index]    = w.entry_line;
        pm_src[w.entry_index]     = w.entry_source_present;
        pm_written[w.entry_index] = 1'b1;
      end
      KIND_MODE: pm_mode = w.new_mode;
      KIND_EVENT: begin
        do_scan  = 1'b1;
        r.notify = w.event_type;
        case (pm_mode)
          MODE_INTO: begin
            if (w.event_type == EV_LINE) begin
              pm_depth    = '0;
              r.break_now = 1'b1;
              do_scan     = 1'b0;
            end
          end
          MODE_OUT: begin
            if (w.event_type == EV_RETURN) begin
              if (pm_depth == 0) pm_mode = MODE_OVER;
              else if (pm_depth != DEPTH_MIN) pm_depth = pm_depth - 16'sd1;
            end
          end
          MODE_OVER: begin
            if (w.event_type == EV_LINE && pm_depth == 0) begin
              r.break_now = 1'b1;
              do_scan     = 1'b0;
            end else if (w.event_type == EV_CALL) begin
              if (pm_depth != DEPTH_MAX) pm_depth = pm_depth + 16'sd1;
            end else if (w.event_type == EV_RETURN) begin
              if (pm_depth != DEPTH_MIN) pm_depth = pm_depth - 16'sd1;
            end
          end
          default: ;
        endcase
        if (do_scan && w.source_present) begin
          for (i = 0; i < scanned_entries(); i++) begin
            if (!pm_src[i]) break;
            if (pm_line[i] == w.line_number) begin
              pm_last     = i[HIT_W-1:0];
              r.hit_found = 1'b1;
              if (w.event_type == EV_LINE) r.break_now = 1'b1;
              break;
            end
          end
        end
      end
      default: ;
    endcase
    r.hit_index = pm_last;
    r.mode_now  = pm_mode;
    return r;
  endfunction

  // True when a scan for this line would reach an entry that was never written.
  function automatic bit scan_hits_unwritten(logic [LINE_W-1:0] line);
    int i;
    for (i = 0; i < scanned_entries(); i++) begin
      if (!pm_written[i]) return 1'b1;
      if (!pm_src[i] || pm_line[i] == line) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int       r;
    int       lim;
    int       j;
    w   = in_word_t'({$urandom, $urandom});
    lim = (scanned_entries() == 0) ? 1 : scanned_entries();
    r   = $urandom_range(0, 99);
    if (r < 55) w.kind = KIND_EVENT;
    else if (r < 75) w.kind = KIND_WRITE;
    else if (r < 94) w.kind = KIND_MODE;
    else w.kind = KIND_NONE;
    if (w.kind == KIND_EVENT) begin
      r = $urandom_range(0, 99);
      j = $urandom_range(0, lim - 1);
      if (r < 50 && pm_written[j]) w.line_number = pm_line[j];
      else if (r < 55) w.line_number = '0;
      else if (r < 60) w.line_number = '1;
      w.source_present = ($urandom_range(0, 99) < 80);
      if (w.source_present && scan_hits_unwritten(w.line_number)) w.source_present = 1'b0;
    end else if (w.kind == KIND_WRITE) begin
      if ($urandom_range(0, 99) < 70) w.entry_index = 8'($urandom_range(0, lim - 1));
      w.entry_source_present = ($urandom_range(0, 99) < 92);
    end
    return w;
  endfunction

  task automatic send_word(in_word_t w, bit fixed, out_word_t want);
    out_word_t p;
    int        r;
    int        gap;
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    p = decide_word(w);
    verdict_q.push_back(fixed ? want : p);
    r   = $urandom_range(0, 99);
    gap = 0;
    if (!burst) begin
      if (r >= 95) gap = $urandom_range(15, 60);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_count(logic [CFG_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    pm_count  = v;
  endtask

  function automatic in_word_t mk_in(kind_e k, ev_e ev, logic [LINE_W-1:0] line, logic src,
                                     logic [7:0] idx, logic [LINE_W-1:0] eline, logic esrc,
                                     mode_e m);
    in_word_t w;
    w.kind                 = k;
    w.event_type           = ev;
    w.line_number          = line;
    w.source_present       = src;
    w.entry_index          = idx;
    w.entry_line           = eline;
    w.entry_source_present = esrc;
    w.new_mode             = m;
    return w;
  endfunction

  function automatic out_word_t mk_out(logic brk, logic [1:0] nt, logic hit,
                                       logic [HIT_W-1:0] idx, mode_e m);
    out_word_t o;
    o.break_now = brk;
    o.notify    = nt;
    o.hit_found = hit;
    o.hit_index = idx;
    o.mode_now  = m;
    return o;
  endfunction

  // Receiver: random stalls and a long hold-off on request.
  initial begin : receiver
    int n;
    forever begin
      @(posedge clk_i);
      n = $urandom_range(0, 99);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (n < 65) begin
        out_stall <= 1'b0;
      end else if (n < 97) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 2)) @(posedge clk_i);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    out_word_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        if (bad_words < 10) $display("unexpected result word %h", out_data);
        bad_words++;
      end else begin
        want = verdict_q.pop_front();
        if (out_data.break_now !== want.break_now || out_data.notify !== want.notify ||
            out_data.hit_found !== want.hit_found || out_data.hit_index !== want.hit_index ||
            out_data.mode_now !== want.mode_now) begin
          if (bad_words < 10)
            $display("mismatch: exp brk %0d ntf %0d hit %0d idx %0d mode %0d, got %0d %0d %0d %0d %0d",
                     want.break_now, want.notify, want.hit_found, want.hit_index, want.mode_now,
                     out_data.break_now, out_data.notify, out_data.hit_found,
                     out_data.hit_index, out_data.mode_now);
          bad_words++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    dir_row_t dir_tab [N_DIRECTED];
    int       phase_count [N_PHASES];
    int       phase_items [N_PHASES];
    in_word_t w;
    int       p;
    int       k;
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_data      = '0;
    burst        = 1'b0;
    hold_req     = 1'b0;
    bad_words    = 0;
    quiet_cycles = 0;
    pm_mode      = MODE_NONE;
    pm_depth     = '0;
    pm_last      = '0;
    pm_count     = '0;
    for (k = 0; k < TABLE_DEPTH; k++) pm_written[k] = 1'b0;

    phase_count = '{511, 256, 0, 1, 2, 5, 12, 30, 3};
    phase_items = '{120, 100, 120, 150, 150, 200, 250, 250, 160};

    // Right after reset nothing is scanned; later rows build a three-entry table by hand.
    dir_tab[0]  = '{NO_CFG, mk_in(KIND_NONE, EV_CALL, 0, 0, 0, 0, 0, MODE_NONE),
                    mk_out(0, NOTIFY_NONE, 0, 0, MODE_NONE)};
    dir_tab[1]  = '{NO_CFG, mk_in(KIND_EVENT, EV_LINE, 0, 1, 0, 0, 0, MODE_NONE),
                    mk_out(0, EV_LINE, 0, 0, MODE_NONE)};
    dir_tab[2]  = '{NO_CFG, mk_in(KIND_EVENT, EV_OTHER, '1, 1, 0, 0, 0, MODE_NONE),
                    mk_out(0, EV_OTHER, 0, 0, MODE_NONE)};
    dir_tab[3]  = '{NO_CFG, mk_in(KIND_WRITE, EV_CALL, 0, 0, 0, '1, 1, MODE_NONE),
                    mk_out(0, NOTIFY_NONE, 0, 0, MODE_NONE)};
    dir_tab[4]  = '{NO_CFG, mk_in(KIND_WRITE, EV_CALL, 0, 0, 1, 0, 1, MODE_NONE),
                    mk_out(0, NOTIFY_NONE, 0, 0, MODE_NONE)};
    dir_tab[5]  = '{NO_CFG, mk_in(KIND_WRITE, EV_CALL, 0, 0, 2, 24'h000123, 0, MODE_NONE),
                    mk_out(0, NOTIFY_NONE, 0, 0, MODE_NONE)};
    dir_tab[6]  = '{NO_CFG, mk_in(KIND_WRITE, EV_CALL, 0, 0, 8'hFF, 24'hABCDEF, 1, MODE_NONE),
                    mk_out(0, NOTIFY_NONE, 0, 0, MODE_NONE)};
    dir_tab[7]  = '{3, mk_in(KIND_EVENT, EV_LINE, 0, 1, 0, 0, 0, MODE_NONE),
                    mk_out(1, EV_LINE, 1, 1, MODE_NONE)};
    dir_tab[8]  = '{NO_CFG, mk_in(KIND_EVENT, EV_CALL, '1, 1, 0, 0, 0, MODE_NONE),
                    mk_out(0, EV_CALL, 1, 0, MODE_NONE)};
    // The scan stops at the entry whose source flag is clear.
    dir_tab[9]  = '{NO_CFG, mk_in(KIND_EVENT, EV_LINE, 24'h000123, 1, 0, 0, 0, MODE_NONE),
                    mk_out(0, EV_LINE, 0, 0, MODE_NONE)};
    dir_tab[10] = '{NO_CFG, mk_in(KIND_EVENT, EV_LINE, 0, 0, 0, 0, 0, MODE_NONE),
                    mk_out(0, EV_LINE, 0, 0, MODE_NONE)};
    dir_tab[11] = '{NO_CFG, mk_in(KIND_MODE, EV_CALL, 0, 0, 0, 0, 0, MODE_INTO),
                    mk_out(0, NOTIFY_NONE, 0, 0, MODE_INTO)};
    dir_tab[12] = '{NO_CFG, mk_in(KIND_EVENT, EV_LINE, 0, 1, 0, 0, 0, MODE_NONE),
                    mk_out(1, EV_LINE, 0, 0, MODE_INTO)};
    dir_tab[13] = '{NO_CFG, mk_in(KIND_EVENT, EV_CALL, 0, 1, 0, 0, 0, MODE_NONE),
                    mk_out(0, EV_CALL, 1, 1, MODE_INTO)};
    dir_tab[14] = '{NO_CFG, mk_in(KIND_MODE, EV_CALL, 0, 0, 0, 0, 0, MODE_OUT),
                    mk_out(0, NOTIFY_NONE, 0, 1, MODE_OUT)};
    dir_tab[15] = '{NO_CFG, mk_in(KIND_EVENT, EV_RETURN, 0, 0, 0, 0, 0, MODE_NONE),
                    mk_out(0, EV_RETURN, 0, 1, MODE_OVER)};
    dir_tab[16] = '{NO_CFG, mk_in(KIND_EVENT, EV_CALL, 0, 0, 0, 0, 0, MODE_NONE),
                    mk_out(0, EV_CALL, 0, 1, MODE_OVER)};
    dir_tab[17] = '{NO_CFG, mk_in(KIND_EVENT, EV_LINE, 0, 0, 0, 0, 0, MODE_NONE),
                    mk_out(0, EV_LINE, 0, 1, MODE_OVER)};
    dir_tab[18] = '{NO_CFG, mk_in(KIND_MODE, EV_CALL, 0, 0, 0, 0, 0, MODE_OUT),
                    mk_out(0, NOTIFY_NONE, 0, 1, MODE_OUT)};
    dir_tab[19] = '{NO_CFG, mk_in(KIND_EVENT, EV_RETURN, 0, 0, 0, 0, 0, MODE_NONE),
                    mk_out(0, EV_RETURN, 0, 1, MODE_OUT)};
    dir_tab[20] = '{NO_CFG, mk_in(KIND_EVENT, EV_RETURN, 0, 0, 0, 0, 0, MODE_NONE),
                    mk_out(0, EV_RETURN, 0, 1, MODE_OVER)};
    dir_tab[21] = '{NO_CFG, mk_in(KIND_EVENT, EV_LINE, 0, 1, 0, 0, 0, MODE_NONE),
                    mk_out(1, EV_LINE, 0, 1, MODE_OVER)};
    // A count above the table depth scans the whole table; this row hits at entry 0.
    dir_tab[22] = '{511, mk_in(KIND_EVENT, EV_OTHER, '1, 1, 0, 0, 0, MODE_NONE),
                    mk_out(0, EV_OTHER, 1, 0, MODE_OVER)};
    dir_tab[23] = '{NO_CFG, mk_in(KIND_MODE, EV_CALL, 0, 0, 0, 0, 0, MODE_NONE),
                    mk_out(0, NOTIFY_NONE, 0, 0, MODE_NONE)};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < N_DIRECTED; k++) begin
      if (dir_tab[k].cfg != NO_CFG) write_count(dir_tab[k].cfg[CFG_W-1:0]);
      send_word(dir_tab[k].w, 1'b1, dir_tab[k].want);
    end

    // Fill the whole table so that long scans never touch an unwritten entry.
    for (k = 0; k < TABLE_DEPTH; k++) begin
      w = in_word_t'({$urandom, $urandom});
      w.kind                 = KIND_WRITE;
      w.entry_index          = k[7:0];
      w.entry_source_present = ($urandom_range(0, 99) != 0);
      send_word(w, 1'b0, '0);
    end

    for (p = 0; p < N_PHASES; p++) begin
      write_count(phase_count[p][CFG_W-1:0]);
      for (k = 0; k < phase_items[p]; k++) begin
        if (p == 5 && k == 20) begin
          hold_req = 1'b1;
          burst    = 1'b1;
        end
        if (p == 5 && k == 60) burst = 1'b0;
        if (p == 6 && k == 120) drain();
        send_word(random_word(), 1'b0, '0);
      end
    end

    drain();
    repeat (300) @(posedge clk_i);
    if (bad_words == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== debug_step_breakpoint_unit.f =====
rtl/dsbu_pkg.sv
rtl/dsbu_ram.sv
rtl/dsbu_step.sv
rtl/dsbu_scan.sv
rtl/debug_step_breakpoint_unit.sv
tb/tb_top.sv
